/* hdl/cddc_pkg.sv */
// ----------------------------------------------------------------------------
// cddc_pkg
// Shared types, constants and calendar tables for the date day count block.
// ----------------------------------------------------------------------------
package cddc_pkg;

  // largest year accepted as valid
  localparam int MAX_YEAR = 9999;

  // register stages from input to output
  localparam int NSTAGE = 4;

  // day number of 1970-01-01 (days before 1970 plus one)
  localparam int EPOCH_DAY_NUM = 719529;

  // reciprocal of 100 for a 14-bit dividend: (y * 5243) >> 19
  localparam int RECIP100     = 5243;
  localparam int RECIP100_SH  = 19;

  // reciprocal of 7 for a 9-bit dividend: (x * 293) >> 11
  localparam int RECIP7       = 293;
  localparam int RECIP7_SH    = 11;

  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_DEC = 4'd12;

  typedef struct packed {
    logic [13:0] year_a;
    logic [3:0]  month_a;
    logic [4:0]  day_a;
    logic [13:0] year_b;
    logic [3:0]  month_b;
    logic [4:0]  day_b;
  } in_t;

  typedef struct packed {
    logic        a_valid;
    logic        b_valid;
    logic        a_leap;
    logic [8:0]  a_day_of_year;
    logic [5:0]  a_week;
    logic [21:0] a_epoch_days;
    logic        a_before_epoch;
    logic [21:0] span_days;
    logic        order_error;
  } out_t;

  // per-stage load enables from the pipeline control
  typedef struct packed {
    logic [NSTAGE-1:0] load;
  } stage_ctl_t;

  // per-date result leaving the date datapath
  typedef struct packed {
    logic        valid;
    logic        leap;
    logic [8:0]  doy;
    logic [22:0] day_num;
    logic        pre_epoch;
  } date_res_t;

  // days in a month of a common year, 0 for codes that are not months
  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // days in the months before month m of a common year
  function automatic logic [8:0] days_before_month(input logic [3:0] m);
    logic [8:0] cum;
    case (m)
      4'd1:    cum = 9'd0;
      4'd2:    cum = 9'd31;
      4'd3:    cum = 9'd59;
      4'd4:    cum = 9'd90;
      4'd5:    cum = 9'd120;
      4'd6:    cum = 9'd151;
      4'd7:    cum = 9'd181;
      4'd8:    cum = 9'd212;
      4'd9:    cum = 9'd243;
      4'd10:   cum = 9'd273;
      4'd11:   cum = 9'd304;
      4'd12:   cum = 9'd334;
      default: cum = 9'd0;
    endcase
    return cum;
  endfunction

endpackage

/* hdl/calendar_date_day_count_top.sv */
// ----------------------------------------------------------------------------
// calendar_date_day_count_top
// Gregorian date pair checker: validity, leap flag, ordinal day, week,
// days since 1970-01-01 and the day span from the first date to the second.
// ----------------------------------------------------------------------------
// The block takes one date pair per cycle while in_ready is high. The result
// passes three datapath stages per date (century split, validity and ordinal
// day, day number) and one output stage that forms the week, the epoch offset
// and the span. Throughput is one word per cycle; a stall on the output fills
// the pipeline and then holds in_ready low until the result word is taken. An
// invalid first date gives zeros in its own fields, and order_error is set with
// span_days zero when a date is invalid or the second date is earlier than the
// first.
module calendar_date_day_count_top
  import cddc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  stage_ctl_t ctl;
  date_res_t  ra;
  date_res_t  rb;

  cddc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ctl       (ctl)
  );

  cddc_date u_date_a (
    .clk   (clk),
    .ctl   (ctl),
    .year  (in_data.year_a),
    .month (in_data.month_a),
    .day   (in_data.day_a),
    .res   (ra)
  );

  cddc_date u_date_b (
    .clk   (clk),
    .ctl   (ctl),
    .year  (in_data.year_b),
    .month (in_data.month_b),
    .day   (in_data.day_b),
    .res   (rb)
  );

  // output stage: week by reciprocal of 7, epoch offset, span and order
  logic [18:0] week_prod;
  logic [22:0] epoch;
  logic [22:0] span;
  logic        order_ok;
  out_t        res_next;

  always_comb begin
    week_prod = 19'(10'(ra.doy) + 10'd5) * 19'(RECIP7);
    epoch     = ra.day_num - 23'(EPOCH_DAY_NUM);
    span      = rb.day_num - ra.day_num;
    order_ok  = ra.valid && rb.valid && (rb.day_num >= ra.day_num);

    res_next                = '0;
    res_next.a_valid        = ra.valid;
    res_next.b_valid        = rb.valid;
    res_next.order_error    = !order_ok;
    if (ra.valid) begin
      res_next.a_leap         = ra.leap;
      res_next.a_day_of_year  = ra.doy;
      res_next.a_week         = 6'd1 + 6'(week_prod[RECIP7_SH +: 8]);
      res_next.a_before_epoch = ra.pre_epoch;
      res_next.a_epoch_days   = ra.pre_epoch ? 22'd0 : epoch[21:0];
    end
    if (order_ok) begin
      res_next.span_days = span[21:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load[NSTAGE-1]) begin
      out_data <= res_next;
    end
  end

  // no span without two valid dates in order
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.order_error |-> out_data.a_valid && out_data.b_valid)
    else $error("span reported for an invalid date pair");

  // an invalid first date clears all of its fields
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.a_valid |->
      out_data.a_day_of_year == '0 && out_data.a_week == '0
      && out_data.a_epoch_days == '0 && !out_data.a_leap && !out_data.a_before_epoch)
    else $error("invalid first date left nonzero fields");

  // a valid first date has a day of year and week in range
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.a_valid |->
      out_data.a_day_of_year != '0 && out_data.a_day_of_year <= 9'd366
      && out_data.a_week != '0 && out_data.a_week <= 6'd54)
    else $error("day of year or week out of range");

  // dates before 1970 carry no epoch offset
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.a_before_epoch |-> out_data.a_epoch_days == '0)
    else $error("epoch offset on a date before 1970");

  // an order error never carries a span
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.order_error |-> out_data.span_days == '0)
    else $error("span reported with an order error");

endmodule

/* hdl/cddc_ctrl.sv */
// ----------------------------------------------------------------------------
// cddc_ctrl
// Valid bits and stage load enables for the date pipeline. A stage loads
// when it is empty or when the stage after it moves on.
// ----------------------------------------------------------------------------
module cddc_ctrl
  import cddc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output stage_ctl_t ctl
);

  logic [NSTAGE-1:0] vld;
  logic [NSTAGE-1:0] rdy;

  // ready ripples back from the output register
  always_comb begin
    rdy[NSTAGE-1] = !vld[NSTAGE-1] || out_ready;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign ctl.load  = rdy;
  assign in_ready  = rdy[0];
  assign out_valid = vld[NSTAGE-1];

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) vld[0] <= in_valid;
      for (int k = 1; k < NSTAGE; k++) begin
        if (rdy[k]) vld[k] <= vld[k-1];
      end
    end
  end

endmodule

/* hdl/cddc_date.sv */
// ----------------------------------------------------------------------------
// cddc_date
// Three-stage datapath for one date: century split, validity and ordinal
// day, then the absolute day number counted from year 0.
// ----------------------------------------------------------------------------
module cddc_date
  import cddc_pkg::*;
(
  input  logic        clk,
  input  stage_ctl_t  ctl,
  input  logic [13:0] year,
  input  logic [3:0]  month,
  input  logic [4:0]  day,
  output date_res_t   res
);

  // stage 1: year / 100 by reciprocal
  logic [26:0] q100_prod;
  logic [13:0] s1_year;
  logic [3:0]  s1_month;
  logic [4:0]  s1_day;
  logic [7:0]  s1_q100;

  assign q100_prod = 27'(year) * 27'(RECIP100);

  always_ff @(posedge clk) begin
    if (ctl.load[0]) begin
      s1_year  <= year;
      s1_month <= month;
      s1_day   <= day;
      s1_q100  <= q100_prod[RECIP100_SH +: 8];
    end
  end

  // stage 2: leap rule, validity, ordinal day, century ceilings
  logic [13:0] r100;
  logic        leap;
  logic [4:0]  len;
  logic        valid;
  logic [8:0]  doy;
  logic [13:0] s2_year;
  logic        s2_valid;
  logic        s2_leap;
  logic [8:0]  s2_doy;
  logic [7:0]  s2_c100;
  logic [12:0] s2_c4;

  always_comb begin
    r100  = s1_year - 14'(s1_q100) * 14'd100;
    leap  = (s1_year[1:0] == 2'b00) && ((r100 != '0) || (s1_q100[1:0] == 2'b00));
    len   = month_len(s1_month) + 5'((s1_month == MONTH_FEB) && leap);
    valid = (s1_year <= 14'(MAX_YEAR)) && (s1_month != 4'd0)
            && (s1_month <= MONTH_DEC) && (s1_day != 5'd0) && (s1_day <= len);
    doy   = days_before_month(s1_month) + 9'(s1_day)
            + 9'(leap && (s1_month > MONTH_FEB));
  end

  always_ff @(posedge clk) begin
    if (ctl.load[1]) begin
      s2_year  <= s1_year;
      s2_valid <= valid;
      s2_leap  <= leap;
      s2_doy   <= doy;
      s2_c100  <= s1_q100 + 8'(r100 != '0);
      s2_c4    <= 13'((15'(s1_year) + 15'd3) >> 2);
    end
  end

  // stage 3: days before the year plus ordinal day
  logic [6:0]  c400;
  logic [22:0] dby;

  always_comb begin
    c400 = 7'((9'(s2_c100) + 9'd3) >> 2);
    dby  = 23'(s2_year) * 23'd365 + 23'(s2_c4) - 23'(s2_c100) + 23'(c400);
  end

  always_ff @(posedge clk) begin
    if (ctl.load[2]) begin
      res.valid     <= s2_valid;
      res.leap      <= s2_leap;
      res.doy       <= s2_doy;
      res.day_num   <= dby + 23'(s2_doy);
      res.pre_epoch <= s2_year < 14'd1970;
    end
  end

endmodule

/* tb/tb_calendar_date_day_count_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_calendar_date_day_count_top
// Self-checking bench for the Gregorian date pair block. Date pair words go
// in over a valid/ready channel in random bursts. Result words come out
// against a receiver that stalls on its own pattern. Each result word is
// checked against a predictor built from closed-form day numbers. Directed
// corner dates come first, then mostly well-formed random pairs mixed with
// raw field noise.
// ----------------------------------------------------------------------------
module tb_calendar_date_day_count_top;
  import cddc_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int RANDOM_WORDS = 1150;
  localparam int MAX_REPORTS  = 10;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  // date pairs waiting to be sent, and predicted results with their inputs
  in_t  date_pair_q[$];
  out_t day_count_q[$];
  in_t  sent_pair_q[$];

  int unsigned cycle_count = 0;
  int unsigned words_sent = 0;
  int unsigned words_checked = 0;
  int unsigned directed_words = 0;
  int unsigned both_valid_seen = 0;
  int unsigned order_err_seen = 0;
  int unsigned mismatch_count = 0;

  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned ready_left = 0;
  int unsigned stall_left = 0;

  calendar_date_day_count_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  // calendar arithmetic for the predictor
  function automatic bit leap_year(int unsigned y);
    if ((y % 4) != 0) return 1'b0;
    if ((y % 100) != 0) return 1'b1;
    return (y % 400) == 0;
  endfunction

  function automatic int unsigned month_days(int unsigned y, int unsigned m);
    case (m)
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11:           return 30;
      2:                     return leap_year(y) ? 29 : 28;
      default:               return 0;
    endcase
  endfunction

  // days in years 0 .. y-1, year 0 counted as leap
  function automatic longint year_start_day(longint y);
    return 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
  endfunction

  function automatic bit date_is_real(int unsigned y, int unsigned m, int unsigned d);
    if (y > MAX_YEAR) return 1'b0;
    if (m < 1 || m > 12) return 1'b0;
    return d >= 1 && d <= month_days(y, m);
  endfunction

  function automatic int unsigned day_of_year(int unsigned y, int unsigned m,
                                              int unsigned d);
    int unsigned sum;
    sum = d;
    for (int unsigned i = 1; i < m && i <= 12; i++) sum += month_days(y, i);
    return sum;
  endfunction

  // expected result word for one date pair
  function automatic out_t calc_day_count(in_t w);
    out_t r;
    bit va, vb;
    int unsigned doy_a;
    longint ep, na, nb, sp;
    r = '0;
    r.order_error = 1'b1;
    doy_a = 0;
    va = date_is_real(w.year_a, w.month_a, w.day_a);
    vb = date_is_real(w.year_b, w.month_b, w.day_b);
    r.a_valid = va;
    r.b_valid = vb;
    if (va) begin
      r.a_leap = leap_year(w.year_a);
      doy_a = day_of_year(w.year_a, w.month_a, w.day_a);
      r.a_day_of_year = 9'(doy_a);
      r.a_week = 6'(1 + (doy_a + 5) / 7);
      if (w.year_a < 1970) begin
        r.a_before_epoch = 1'b1;
      end else begin
        ep = year_start_day(w.year_a) - year_start_day(1970) + doy_a - 1;
        r.a_epoch_days = ep[21:0];
      end
    end
    if (va && vb) begin
      na = year_start_day(w.year_a) + doy_a;
      nb = year_start_day(w.year_b) + day_of_year(w.year_b, w.month_b, w.day_b);
      if (nb >= na) begin
        sp = nb - na;
        r.span_days = sp[21:0];
        r.order_error = 1'b0;
      end
    end
    return r;
  endfunction

  task automatic add_pair(int unsigned ya, int unsigned ma, int unsigned da,
                          int unsigned yb, int unsigned mb, int unsigned db);
    in_t w;
    w.year_a  = 14'(ya);
    w.month_a = 4'(ma);
    w.day_a   = 5'(da);
    w.year_b  = 14'(yb);
    w.month_b = 4'(mb);
    w.day_b   = 5'(db);
    date_pair_q.push_back(w);
  endtask

  // random pair: mostly a real first date with a related second date
  task automatic gen_date_pair();
    int unsigned ya, ma, da, yb, mb, db, len, pick;
    if ($urandom_range(0, 99) < 20) begin
      add_pair($urandom_range(0, 16383), $urandom_range(0, 15), $urandom_range(0, 31),
               $urandom_range(0, 16383), $urandom_range(0, 15), $urandom_range(0, 31));
    end else begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: ya = $urandom_range(0, 9999);
        5, 6:          ya = $urandom_range(1960, 1980);
        7:             ya = 100 * $urandom_range(0, 99);
        8:             ya = $urandom_range(0, 3);
        default:       ya = $urandom_range(9990, 9999);
      endcase
      ma = $urandom_range(1, 12);
      len = month_days(ya, ma);
      pick = $urandom_range(0, 19);
      if (pick == 0) da = len + 1;
      else if (pick == 1) da = len;
      else da = $urandom_range(1, len);
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        yb = ya; mb = ma; db = da;
      end else if (pick <= 5) begin
        yb = ya + ($urandom_range(0, 1) ? 0 : $urandom_range(0, 50));
        if (yb > 9999) yb = 9999;
        mb = $urandom_range(1, 12);
        db = $urandom_range(1, month_days(yb, mb));
      end else if (pick <= 8) begin
        yb = $urandom_range(0, 9999);
        mb = $urandom_range(1, 12);
        db = $urandom_range(1, month_days(yb, mb));
      end else begin
        yb = $urandom_range(0, 10005);
        mb = $urandom_range(0, 15);
        db = $urandom_range(0, 31);
      end
      add_pair(ya, ma, da, yb, mb, db);
    end
  endtask

  // hold until every queued word is taken and every result has come back
  task automatic drain_all();
    while (date_pair_q.size() != 0 || in_valid || day_count_q.size() != 0)
      @(negedge clk);
  endtask

  // sender: bursts of words with random gaps
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        day_count_q.push_back(calc_day_count(in_data));
        sent_pair_q.push_back(in_data);
        words_sent++;
      end
      if (!in_valid || in_ready) begin
        if (burst_left == 0 && gap_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
        if (burst_left > 0 && date_pair_q.size() != 0) begin
          in_data <= date_pair_q.pop_front();
          in_valid <= 1'b1;
          burst_left--;
        end else begin
          in_valid <= 1'b0;
          if (burst_left == 0) gap_left--;
        end
      end
    end
  end

  // receiver: check each result word, then stall on its own pattern
  always @(posedge clk) begin
    out_t exp_w;
    in_t  src_w;
    if (!rst && out_valid && out_ready) begin
      if (day_count_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected result word at cycle %0d", cycle_count);
      end else begin
        exp_w = day_count_q.pop_front();
        src_w = sent_pair_q.pop_front();
        words_checked++;
        if (exp_w.a_valid && exp_w.b_valid) both_valid_seen++;
        if (exp_w.order_error) order_err_seen++;
        if (out_data.a_valid !== exp_w.a_valid || out_data.b_valid !== exp_w.b_valid ||
            out_data.a_leap !== exp_w.a_leap ||
            out_data.a_day_of_year !== exp_w.a_day_of_year ||
            out_data.a_week !== exp_w.a_week ||
            out_data.a_epoch_days !== exp_w.a_epoch_days ||
            out_data.a_before_epoch !== exp_w.a_before_epoch ||
            out_data.span_days !== exp_w.span_days ||
            out_data.order_error !== exp_w.order_error) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("mismatch on %0d-%0d-%0d / %0d-%0d-%0d", src_w.year_a, src_w.month_a,
                     src_w.day_a, src_w.year_b, src_w.month_b, src_w.day_b);
            $display("  exp va=%0d vb=%0d leap=%0d doy=%0d wk=%0d ep=%0d pre=%0d span=%0d err=%0d",
                     exp_w.a_valid, exp_w.b_valid, exp_w.a_leap, exp_w.a_day_of_year,
                     exp_w.a_week, exp_w.a_epoch_days, exp_w.a_before_epoch,
                     exp_w.span_days, exp_w.order_error);
            $display("  got va=%0d vb=%0d leap=%0d doy=%0d wk=%0d ep=%0d pre=%0d span=%0d err=%0d",
                     out_data.a_valid, out_data.b_valid, out_data.a_leap,
                     out_data.a_day_of_year, out_data.a_week, out_data.a_epoch_days,
                     out_data.a_before_epoch, out_data.span_days, out_data.order_error);
          end
        end
      end
    end
    if (ready_left == 0 && stall_left == 0) begin
      ready_left = $urandom_range(1, 30);
      stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
    end
    if (ready_left > 0) begin
      out_ready <= 1'b1;
      ready_left--;
    end else begin
      out_ready <= 1'b0;
      stall_left--;
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // stimulus and end of run
  initial begin
    // equal dates on the epoch, widest span, last valid date
    add_pair(1970, 1, 1, 1970, 1, 1);
    add_pair(0, 1, 1, 9999, 12, 31);
    add_pair(9999, 12, 31, 9999, 12, 31);
    // leap rules: 400 year, 100 year, common year, year zero
    add_pair(2000, 2, 29, 2000, 3, 1);
    add_pair(1900, 2, 29, 1900, 3, 1);
    add_pair(2023, 2, 29, 2023, 3, 1);
    add_pair(0, 2, 29, 0, 12, 31);
    add_pair(2100, 2, 29, 2100, 2, 28);
    add_pair(2004, 2, 29, 2005, 2, 28);
    add_pair(1600, 2, 29, 2400, 2, 29);
    // last day of a leap year, highest week
    add_pair(2024, 12, 31, 2025, 1, 1);
    // second date earlier
    add_pair(2020, 3, 1, 2020, 2, 28);
    add_pair(2000, 1, 1, 1999, 12, 31);
    add_pair(1970, 1, 2, 1970, 1, 1);
    // around the epoch and across a year boundary
    add_pair(1969, 12, 31, 1970, 1, 1);
    add_pair(1999, 12, 31, 2000, 1, 1);
    add_pair(2019, 7, 4, 2019, 7, 4);
    // bad second date, bad months, bad days, years past the limit
    add_pair(2021, 6, 15, 2021, 4, 31);
    add_pair(2021, 1, 31, 2021, 13, 1);
    add_pair(2000, 0, 10, 2000, 1, 0);
    add_pair(10000, 1, 1, 2000, 1, 1);
    add_pair(9999, 1, 1, 10000, 1, 1);
    add_pair(16383, 15, 31, 16383, 15, 31);
    add_pair(0, 0, 0, 0, 0, 0);
    directed_words = date_pair_q.size();

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    drain_all();
    for (int i = 0; i < RANDOM_WORDS / 2; i++) gen_date_pair();
    drain_all();
    for (int i = RANDOM_WORDS / 2; i < RANDOM_WORDS; i++) gen_date_pair();
    drain_all();
    repeat (NSTAGE * 4 + 20) @(negedge clk);

    if (day_count_q.size() != 0) begin
      mismatch_count += day_count_q.size();
      $display("%0d result words never arrived", day_count_q.size());
    end
    $display("sent %0d date pair words (%0d directed), checked %0d results",
             words_sent, directed_words, words_checked);
    $display("%0d pairs with both dates valid, %0d with order or validity error",
             both_valid_seen, order_err_seen);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

/* calendar_date_day_count_top.f */
hdl/cddc_pkg.sv
hdl/cddc_ctrl.sv
hdl/cddc_date.sv
hdl/calendar_date_day_count_top.sv
tb/tb_calendar_date_day_count_top.sv
